@@ rtl/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  // Bytes of header in front of every block's payload.
  localparam logic [31:0] HDR_BYTES = 32'd16;

  // Result status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NULL    = 2'd1;
  localparam logic [1:0] STAT_OOM     = 2'd2;
  localparam logic [1:0] STAT_UNKNOWN = 2'd3;

  // Request operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Register select (paddr bit 2).
  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] request_size;
    logic [31:0] block_address;
  } in_t;

  typedef struct packed {
    logic [31:0] granted_address;
    logic [1:0]  status;
    logic        reused;
  } out_t;

  // One row of the block table.
  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] size;
    logic        free;
  } entry_t;

  // Configuration register values seen by the core.
  typedef struct packed {
    logic [31:0] heap_base;
    logic [31:0] heap_limit;
  } cfg_t;

endpackage

@@ rtl/ffba_table.sv @@
// ----------------------------------------------------------------------------
// ffba_table
// Block table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffba_table #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_idx,
  output ffba_pkg::entry_t      rd_data,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_idx,
  input  ffba_pkg::entry_t      wr_data
);

  ffba_pkg::entry_t mem [DEPTH];
  ffba_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/ffba_regs.sv @@
// ----------------------------------------------------------------------------
// ffba_regs
// APB-style configuration registers: heap base and heap limit.
// ----------------------------------------------------------------------------
module ffba_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output ffba_pkg::cfg_t     cfg
);

  logic [31:0] base_r;
  logic [31:0] limit_r;
  logic        wr_stb;

  assign pready = 1'b1;
  assign wr_stb = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= 32'd0;
      limit_r <= 32'd65536;
    end else if (wr_stb) begin
      unique case (paddr[2])
        ffba_pkg::REG_HEAP_BASE:  base_r  <= pwdata;
        ffba_pkg::REG_HEAP_LIMIT: limit_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ffba_pkg::REG_HEAP_BASE:  prdata = base_r;
      ffba_pkg::REG_HEAP_LIMIT: prdata = limit_r;
      default:                  prdata = 32'd0;
    endcase
  end

  assign cfg.heap_base  = base_r;
  assign cfg.heap_limit = limit_r;

endmodule

@@ rtl/first_fit_block_allocator_top.sv @@
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit heap allocator over a block table held in a synchronous memory.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                          Direction  Transaction
//  --------  -----------------------------  ---------  ---------------------
//  input     in_valid, in_stall, in_data    in         alloc or free request
//  result    out_valid, out_stall, out_data out        address/status/reused
//  config    psel..pready, paddr, p*data    in/out     heap_base, heap_limit
//
//  The table scan makes one memory read per live entry over the single read
//  port; a hit ends the scan early, and a zero size or null address skips
//  the scan. Reset (rst_n, synchronous) clears the block count and heap
//  top; table rows are never read past the count, so the memory is not
//  cleared. A stalled result sits in the output register while the next
//  request is taken and scanned; only its hand-off waits on out_stall.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  ffba_pkg::in_t       in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output ffba_pkg::out_t      out_data,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  ffba_pkg::cfg_t cfg;

  // Control state
  state_t           state_r,     state_nxt;
  logic [CNT_W-1:0] count_r,     count_nxt;
  logic [31:0]      top_r,       top_nxt;
  logic [CNT_W-1:0] issue_r,     issue_nxt;
  logic             chk_valid_r, chk_valid_nxt;
  logic             hit_r,       hit_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Request payload and scan results
  logic             op_r,        op_nxt;
  logic [31:0]      size_r,      size_nxt;
  logic [31:0]      target_r,    target_nxt;   // table offset the free address maps to
  logic [33:0]      end_r,       end_nxt;      // heap end after an append, unwrapped
  logic [IDX_W-1:0] chk_idx_r,   chk_idx_nxt;
  logic [IDX_W-1:0] hit_idx_r,   hit_idx_nxt;
  ffba_pkg::entry_t hit_ent_r,   hit_ent_nxt;
  ffba_pkg::out_t   res_r,       res_nxt;
  ffba_pkg::out_t   out_data_r,  out_data_nxt;

  // Table ports
  logic             rd_en;
  logic [IDX_W-1:0] rd_idx;
  ffba_pkg::entry_t rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  ffba_pkg::entry_t wr_data;

  logic             match;
  logic             is_zero;
  logic             out_free;

  ffba_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ffba_table #(
    .DEPTH (MAX_BLOCKS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Output register frees up when empty or being taken this cycle.
  assign out_free = !out_valid_r || !out_stall;

  // Zero size on allocate, null address on free.
  assign is_zero = (in_data.operation == ffba_pkg::OP_ALLOC) ?
                   (in_data.request_size == 32'd0) : (in_data.block_address == 32'd0);

  // Row returned by the table this cycle qualifies?
  assign match = (op_r == ffba_pkg::OP_ALLOC) ?
                 (rd_data.free && (rd_data.size >= size_r)) :
                 (rd_data.offset == target_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    top_nxt       = top_r;
    issue_nxt     = issue_r;
    chk_valid_nxt = 1'b0;
    hit_nxt       = hit_r;
    op_nxt        = op_r;
    size_nxt      = size_r;
    target_nxt    = target_r;
    end_nxt       = end_r;
    chk_idx_nxt   = chk_idx_r;
    hit_idx_nxt   = hit_idx_r;
    hit_ent_nxt   = hit_ent_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    rd_en   = 1'b0;
    rd_idx  = issue_r[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_idx  = hit_idx_r;
    wr_data = hit_ent_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_data.operation;
          size_nxt   = in_data.request_size;
          target_nxt = in_data.block_address - cfg.heap_base - ffba_pkg::HDR_BYTES;
          end_nxt    = {2'b00, top_r} + {2'b00, ffba_pkg::HDR_BYTES}
                       + {2'b00, in_data.request_size};
          issue_nxt  = '0;
          hit_nxt    = 1'b0;
          if (is_zero) begin
            res_nxt   = '{granted_address: 32'd0, status: ffba_pkg::STAT_NULL, reused: 1'b0};
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue one read per cycle; check the row that came back.
        if (issue_r < count_r) begin
          rd_en         = 1'b1;
          issue_nxt     = issue_r + CNT_W'(1);
          chk_valid_nxt = 1'b1;
          chk_idx_nxt   = issue_r[IDX_W-1:0];
        end
        if (chk_valid_r && match) begin
          hit_nxt       = 1'b1;
          hit_idx_nxt   = chk_idx_r;
          hit_ent_nxt   = rd_data;
          chk_valid_nxt = 1'b0;
          state_nxt     = S_DECIDE;
        end else if (!chk_valid_r && (issue_r >= count_r)) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        state_nxt = S_FINISH;
        if (op_r == ffba_pkg::OP_ALLOC) begin
          if (hit_r) begin
            // Reuse whole, no split.
            wr_en        = 1'b1;
            wr_idx       = hit_idx_r;
            wr_data      = hit_ent_r;
            wr_data.free = 1'b0;
            res_nxt = '{granted_address: cfg.heap_base + hit_ent_r.offset + ffba_pkg::HDR_BYTES,
                        status: ffba_pkg::STAT_OK, reused: 1'b1};
          end else if ((count_r >= CNT_W'(MAX_BLOCKS)) || (end_r > {2'b00, cfg.heap_limit})) begin
            res_nxt = '{granted_address: 32'd0, status: ffba_pkg::STAT_OOM, reused: 1'b0};
          end else begin
            // Append at the heap top.
            wr_en   = 1'b1;
            wr_idx  = count_r[IDX_W-1:0];
            wr_data = '{offset: top_r, size: size_r, free: 1'b0};
            count_nxt = count_r + CNT_W'(1);
            top_nxt   = end_r[31:0];
            res_nxt = '{granted_address: cfg.heap_base + top_r + ffba_pkg::HDR_BYTES,
                        status: ffba_pkg::STAT_OK, reused: 1'b0};
          end
        end else begin
          if (hit_r) begin
            if ((CNT_W'(hit_idx_r) + CNT_W'(1)) == count_r) begin
              // Last block: drop it, heap top falls back.
              top_nxt   = hit_ent_r.offset;
              count_nxt = CNT_W'(hit_idx_r);
            end else begin
              wr_en        = 1'b1;
              wr_idx       = hit_idx_r;
              wr_data      = hit_ent_r;
              wr_data.free = 1'b1;
            end
            res_nxt = '{granted_address: 32'd0, status: ffba_pkg::STAT_OK, reused: 1'b0};
          end else begin
            res_nxt = '{granted_address: 32'd0, status: ffba_pkg::STAT_UNKNOWN, reused: 1'b0};
          end
        end
      end

      S_FINISH: begin
        if (out_free) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      top_r       <= 32'd0;
      issue_r     <= '0;
      chk_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      top_r       <= top_nxt;
      issue_r     <= issue_nxt;
      chk_valid_r <= chk_valid_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    size_r     <= size_nxt;
    target_r   <= target_nxt;
    end_r      <= end_nxt;
    chk_idx_r  <= chk_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_ent_r  <= hit_ent_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the first-fit block allocator.
// A directed table runs first, then several random phases, each under its own
// heap_base / heap_limit setting. A behavioral copy of the block table in the
// testbench predicts every result; results are checked in order, by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH   = 64;   // table rows in the DUT
  localparam int HOLD_CYCLES = 300;  // long result-side hold-off
  localparam int MAX_SHOWN   = 10;   // mismatches printed in full
  localparam logic [2:0] ADDR_BASE  = {ffba_pkg::REG_HEAP_BASE, 2'b00};
  localparam logic [2:0] ADDR_LIMIT = {ffba_pkg::REG_HEAP_LIMIT, 2'b00};

  // --------------------------------------------------------------------------
  // Clock, reset and DUT hookup
  // --------------------------------------------------------------------------
  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  ffba_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  ffba_pkg::out_t out_data;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [2:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  always #6 clk = ~clk;

  first_fit_block_allocator_top #(
    .MAX_BLOCKS(TBL_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // --------------------------------------------------------------------------
  // Shadow of the allocator: block table, heap top and config registers.
  // Updated once per accepted request transaction, in acceptance order.
  // --------------------------------------------------------------------------
  logic [31:0] tbl_offset [TBL_DEPTH];
  logic [31:0] tbl_size   [TBL_DEPTH];
  bit          tbl_free   [TBL_DEPTH];
  int          tbl_count   = 0;
  logic [31:0] heap_top_sh = '0;
  logic [31:0] cfg_base    = '0;
  logic [31:0] cfg_limit   = 32'd65536;

  // Outcome tallies for the closing summary
  int n_granted = 0, n_reused = 0, n_freed = 0;
  int n_null = 0, n_oom = 0, n_unknown = 0;
  int n_table_full = 0;

  ffba_pkg::out_t pending_results[$];  // predicted results, oldest first
  int   mismatches = 0;
  int   results_seen = 0;

  // Long hold-off request, picked up by the result-side process
  bit hold_req = 1'b0;
  // Sender burst counter: while nonzero, no gaps between transactions
  int send_calm = 0;

  // Payload address of a table row under the current heap_base (wraps).
  function automatic logic [31:0] payload_of(int idx);
    return cfg_base + tbl_offset[idx] + ffba_pkg::HDR_BYTES;
  endfunction

  // Expected result of one request; advances the shadow table.
  function automatic ffba_pkg::out_t predict_request(ffba_pkg::in_t req);
    ffba_pkg::out_t res;
    int             hit;
    logic [33:0]    end_sum;
    res = '0;
    res.status = ffba_pkg::STAT_OK;
    hit = -1;
    if (req.operation == ffba_pkg::OP_ALLOC) begin
      if (req.request_size == '0) begin
        res.status = ffba_pkg::STAT_NULL;
        n_null++;
      end else begin
        // first fit over live rows, no split
        for (int i = 0; i < tbl_count; i++) begin
          if (hit < 0 && tbl_free[i] && tbl_size[i] >= req.request_size) hit = i;
        end
        if (hit >= 0) begin
          tbl_free[hit] = 1'b0;
          res.granted_address = payload_of(hit);
          res.reused = 1'b1;
          n_granted++;
          n_reused++;
        end else begin
          // append at the top; the sum must not wrap
          end_sum = {2'b00, heap_top_sh} + {2'b00, ffba_pkg::HDR_BYTES}
                    + {2'b00, req.request_size};
          if (tbl_count >= TBL_DEPTH || end_sum > {2'b00, cfg_limit}) begin
            res.status = ffba_pkg::STAT_OOM;
            n_oom++;
            if (tbl_count >= TBL_DEPTH) n_table_full++;
          end else begin
            tbl_offset[tbl_count] = heap_top_sh;
            tbl_size[tbl_count]   = req.request_size;
            tbl_free[tbl_count]   = 1'b0;
            res.granted_address   = payload_of(tbl_count);
            tbl_count++;
            heap_top_sh = end_sum[31:0];
            n_granted++;
          end
        end
      end
    end else begin
      if (req.block_address == '0) begin
        res.status = ffba_pkg::STAT_NULL;
        n_null++;
      end else begin
        // first row in table order whose payload address matches
        for (int i = 0; i < tbl_count; i++) begin
          if (hit < 0 && payload_of(i) == req.block_address) hit = i;
        end
        if (hit < 0) begin
          res.status = ffba_pkg::STAT_UNKNOWN;
          n_unknown++;
        end else if (hit == tbl_count - 1) begin
          // last row: drop it, top falls back
          heap_top_sh = tbl_offset[hit];
          tbl_count = hit;
          n_freed++;
        end else begin
          tbl_free[hit] = 1'b1;
          n_freed++;
        end
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic ffba_pkg::in_t mk_req(logic op, logic [31:0] size, logic [31:0] addr);
    ffba_pkg::in_t req;
    req.operation     = op;
    req.request_size  = size;
    req.block_address = addr;
    return req;
  endfunction

  function automatic ffba_pkg::out_t mk_res(logic [31:0] addr, logic [1:0] status,
                                            logic reused);
    ffba_pkg::out_t res;
    res.granted_address = addr;
    res.status          = status;
    res.reused          = reused;
    return res;
  endfunction

  // Random request. Mostly well-formed: allocs of modest size and frees of
  // live blocks (a third of them the last row, so the top moves). The rest is
  // zero sizes, huge sizes, null, off-by-one and random addresses.
  function automatic ffba_pkg::in_t random_request(int alloc_pct);
    ffba_pkg::in_t req;
    int            pick;
    int            idx;
    req = mk_req(ffba_pkg::OP_ALLOC, $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < alloc_pct) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) req.request_size = $urandom_range(1, 1500);
      else if (pick < 90) req.request_size = '0;
      else if (pick < 95) req.request_size = $urandom_range(1, 32'h0100_0000);
    end else if (pick < 90 && tbl_count > 0) begin
      req.operation = ffba_pkg::OP_FREE;
      if ($urandom_range(0, 2) == 0) idx = tbl_count - 1;
      else idx = $urandom_range(0, tbl_count - 1);
      req.block_address = payload_of(idx);
    end else begin
      req.operation = ffba_pkg::OP_FREE;
      pick = $urandom_range(0, 3);
      if (pick == 0) req.block_address = '0;
      else if (pick == 1 && tbl_count > 0)
        req.block_address = payload_of($urandom_range(0, tbl_count - 1)) + 32'd1;
    end
    return req;
  endfunction

  // Gap before the next request: mostly none, some short, a few long,
  // with occasional bursts of back-to-back transactions.
  function automatic int pick_gap();
    int pick;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) send_calm = $urandom_range(20, 60);
    if (pick < 70) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Request channel: drive on falling edge, hold until accepted.
  // --------------------------------------------------------------------------
  task automatic send_req(ffba_pkg::in_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // --------------------------------------------------------------------------
  // APB access: setup cycle, then access cycle until pready.
  // --------------------------------------------------------------------------
  task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(logic [2:0] addr, logic [31:0] want);
    logic [31:0] got;
    apb_access(1'b0, addr, '0, got);
    if (got !== want)
      report_mismatch($sformatf("register @%0d read %h, expected %h", addr, got, want));
  endtask

  // Only called with the block idle: no request in flight, no result pending.
  task automatic set_config(logic [31:0] base, logic [31:0] limit);
    logic [31:0] unused;
    apb_access(1'b1, ADDR_BASE, base, unused);
    apb_access(1'b1, ADDR_LIMIT, limit, unused);
    cfg_base  = base;
    cfg_limit = limit;
    check_reg(ADDR_BASE, base);
    check_reg(ADDR_LIMIT, limit);
  endtask

  // Drain: every predicted result handed off, then a few quiet cycles.
  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One random phase under a fresh register setting. hold_at < 0: no hold.
  task automatic run_phase(logic [31:0] base, logic [31:0] limit, int count,
                           int alloc_pct, int hold_at);
    ffba_pkg::in_t req;
    set_config(base, limit);
    for (int k = 0; k < count; k++) begin
      req = random_request(alloc_pct);
      send_req(req);
      pending_results.push_back(predict_request(req));
      if (k == hold_at) hold_req = 1'b1;
    end
    @(negedge clk);
    in_valid <= 1'b0;
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall pattern, changed on the falling edge.
  // A pending hold request wins and keeps stall high through the long hold-off
  // while the sender keeps offering, so the DUT backs up into in_stall.
  // --------------------------------------------------------------------------
  initial begin : result_stall
    int hold_left;
    int stall_left;
    int calm_left;
    int pick;
    hold_left  = 0;
    stall_left = 0;
    calm_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (calm_left > 0) begin
        calm_left--;
        out_stall <= 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          calm_left = $urandom_range(20, 80);
          out_stall <= 1'b0;
        end else if (pick < 78) begin
          out_stall <= 1'b0;
        end else if (pick < 96) begin
          stall_left = $urandom_range(0, 2);
          out_stall <= 1'b1;
        end else begin
          stall_left = $urandom_range(10, 40);
          out_stall <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: each accepted result against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    ffba_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        want = pending_results.pop_front();
        if (out_data.granted_address !== want.granted_address)
          report_mismatch($sformatf("granted_address %h, expected %h",
                                    out_data.granted_address, want.granted_address));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_data.status, want.status));
        if (out_data.reused !== want.reused)
          report_mismatch($sformatf("reused %0b, expected %0b",
                                    out_data.reused, want.reused));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed table. Rows with a typed result are checked against it; the rest
  // take the predictor's word. Heap starts at base 0, limit 64 KiB.
  // --------------------------------------------------------------------------
  typedef struct {
    ffba_pkg::in_t  req;
    bit             typed;
    ffba_pkg::out_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void add_row(ffba_pkg::in_t req, bit typed, ffba_pkg::out_t want);
    dir_row_t row;
    row.req   = req;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  function automatic void build_directed();
    // zero size and null address
    add_row(mk_req(ffba_pkg::OP_ALLOC, 32'd0, 32'hFFFF_FFFF), 1'b1,
            mk_res('0, ffba_pkg::STAT_NULL, 1'b0));
    add_row(mk_req(ffba_pkg::OP_FREE, 32'hFFFF_FFFF, 32'd0), 1'b1,
            mk_res('0, ffba_pkg::STAT_NULL, 1'b0));
    // empty table: nothing to match
    add_row(mk_req(ffba_pkg::OP_FREE, 32'd0, 32'd16), 1'b1,
            mk_res('0, ffba_pkg::STAT_UNKNOWN, 1'b0));
    // top + header + max size must not wrap past the limit
    add_row(mk_req(ffba_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'd0), 1'b1,
            mk_res('0, ffba_pkg::STAT_OOM, 1'b0));
    // exact fit of the whole heap, then one byte more fails
    add_row(mk_req(ffba_pkg::OP_ALLOC, 32'd65520, 32'd0), 1'b1,
            mk_res(32'd16, ffba_pkg::STAT_OK, 1'b0));
    add_row(mk_req(ffba_pkg::OP_ALLOC, 32'd1, 32'd0), 1'b1,
            mk_res('0, ffba_pkg::STAT_OOM, 1'b0));
    // last block dropped, top back to zero
    add_row(mk_req(ffba_pkg::OP_FREE, 32'd0, 32'd16), 1'b1,
            mk_res('0, ffba_pkg::STAT_OK, 1'b0));
    // three blocks: payloads at 16, 132, 348
    add_row(mk_req(ffba_pkg::OP_ALLOC, 32'd100, 32'd0), 1'b0, '0);
    add_row(mk_req(ffba_pkg::OP_ALLOC, 32'd200, 32'd0), 1'b0, '0);
    add_row(mk_req(ffba_pkg::OP_ALLOC, 32'd50, 32'd0), 1'b0, '0);
    // middle free, then double free of the same block
    add_row(mk_req(ffba_pkg::OP_FREE, 32'd0, 32'd132), 1'b0, '0);
    add_row(mk_req(ffba_pkg::OP_FREE, 32'd0, 32'd132), 1'b0, '0);
    // too big for the hole: append; then fits the hole: reuse, no split
    add_row(mk_req(ffba_pkg::OP_ALLOC, 32'd300, 32'd0), 1'b0, '0);
    add_row(mk_req(ffba_pkg::OP_ALLOC, 32'd150, 32'd0), 1'b0, '0);
    add_row(mk_req(ffba_pkg::OP_ALLOC, 32'd200, 32'd0), 1'b0, '0);
    // unknown addresses: max value and a misaligned one
    add_row(mk_req(ffba_pkg::OP_FREE, 32'd0, 32'hFFFF_FFFF), 1'b1,
            mk_res('0, ffba_pkg::STAT_UNKNOWN, 1'b0));
    add_row(mk_req(ffba_pkg::OP_FREE, 32'd0, 32'd133), 1'b1,
            mk_res('0, ffba_pkg::STAT_UNKNOWN, 1'b0));
    // free a 50-byte hole, then one byte too big for it, then an exact fit
    add_row(mk_req(ffba_pkg::OP_FREE, 32'd0, 32'd348), 1'b0, '0);
    add_row(mk_req(ffba_pkg::OP_ALLOC, 32'd51, 32'd0), 1'b0, '0);
    add_row(mk_req(ffba_pkg::OP_ALLOC, 32'd50, 32'd0), 1'b0, '0);
    // ignored fields carry all ones
    add_row(mk_req(ffba_pkg::OP_ALLOC, 32'd1, 32'hFFFF_FFFF), 1'b0, '0);
    add_row(mk_req(ffba_pkg::OP_FREE, 32'hFFFF_FFFF, 32'd1013), 1'b0, '0);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    ffba_pkg::out_t pred;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // register reset values
    check_reg(ADDR_BASE, 32'd0);
    check_reg(ADDR_LIMIT, 32'd65536);

    build_directed();
    foreach (dir_rows[r]) begin
      send_req(dir_rows[r].req);
      pred = predict_request(dir_rows[r].req);
      pending_results.push_back(dir_rows[r].typed ? dir_rows[r].want : pred);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    wait_idle();

    // Phase 1: alloc-heavy so the table reaches all 64 rows; the long
    // result hold-off lands early in this phase.
    run_phase(32'h1000_0000, 32'd65536, 160, 70, 40);
    // Phase 2: both registers at all ones; payload addresses wrap, huge
    // appends fit until the top nears 4 GiB.
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 110, 55, -1);
    // Phase 3: limit 0, below the current top: appends fail, reuse works.
    run_phase($urandom, 32'd0, 60, 50, -1);
    // Phase 4: small heap at base 0.
    run_phase(32'd0, 32'd4096, 100, 50, -1);
    // Phase 5: random setting.
    run_phase($urandom, $urandom_range(2000, 200000), 120, 55, -1);

    repeat (80) @(posedge clk);

    $display("Run covered %0d results: %0d grants (%0d reused), %0d frees,",
             results_seen, n_granted, n_reused, n_freed);
    $display("  %0d null/zero, %0d out of memory (%0d with table full), %0d unknown.",
             n_null, n_oom, n_table_full, n_unknown);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (full-table scans, long stalls).
  initial begin : watchdog
    #10ms;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
